[rtl/qigm_pkg.sv]
// ----------------------------------------------------------------------------
// qigm_pkg
// Constants, types and helpers for the quadrotor input gain matrix.
// ----------------------------------------------------------------------------
package qigm_pkg;

    // Q30 constants
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;
    localparam logic        [33:0] Q30_PI      = 34'd3373259426;
    localparam logic        [33:0] Q30_HALF_PI = 34'd1686629713;
    localparam logic        [33:0] Q30_TWO_PI  = 34'd6746518852;
    localparam logic signed [33:0] CORDIC_K    = 34'sd652032874;
    localparam logic signed [31:0] SEC_FLOOR   = 32'sd16384;

    // configuration register indexes
    localparam logic [1:0] CFG_INV_MASS       = 2'd0;
    localparam logic [1:0] CFG_INV_INERTIA_XY = 2'd1;
    localparam logic [1:0] CFG_INV_INERTIA_Z  = 2'd2;

    localparam logic signed [67:0] SAT_MAX = 68'sd2147483647;
    localparam logic signed [67:0] SAT_MIN = -68'sd2147483648;

    // results that ride alongside the secant dividers
    typedef struct packed {
        logic signed [31:0] out0;
        logic signed [31:0] out1;
        logic signed [31:0] out2;
        logic signed [31:0] out5;
        logic signed [31:0] out6;
        logic               flag;
    } carry_t;

    // one restoring divider lane
    typedef struct packed {
        logic [31:0] rem;
        logic [31:0] low;
        logic [31:0] quo;
        logic        neg;
        logic        ovf;
    } div_lane_t;

    function automatic logic [33:0] atan_q30(input int idx);
        logic [33:0] v;
        case (idx)
            0:  v = 34'd843314857;
            1:  v = 34'd497837829;
            2:  v = 34'd263043837;
            3:  v = 34'd133525159;
            4:  v = 34'd67021687;
            5:  v = 34'd33543516;
            6:  v = 34'd16775851;
            7:  v = 34'd8388437;
            8:  v = 34'd4194283;
            9:  v = 34'd2097149;
            31: v = 34'd1;
            default: v = (idx < 31) ? (34'd1 << (30 - idx)) : 34'd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [67:0] rnd30(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v + 68'sd536870912;
        return t >>> 30;
    endfunction

    function automatic logic signed [31:0] sat32(input logic signed [67:0] v);
        logic signed [67:0] t;
        t = v;
        if (t > SAT_MAX)
            t = SAT_MAX;
        if (t < SAT_MIN)
            t = SAT_MIN;
        return t[31:0];
    endfunction

endpackage

[rtl/quadrotor_input_gain_matrix.sv]
// ----------------------------------------------------------------------------
// quadrotor_input_gain_matrix
// Ten nonzero entries of a quadrotor control input gain matrix from Euler angles.
// ----------------------------------------------------------------------------
// Stages: NIT = min(CORDIC_ITERATIONS, 32) CORDIC stages and RED angle
//   reduction steps.
// Throughput: one item per cycle; every stage advances together, paced by the
//   output register and m_axis_tready.
// Reset: rst_n clears all valid bits and loads the gain registers with 1.0.
module quadrotor_input_gain_matrix
    import qigm_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    // config write channel
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    // input items
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,   // roll_angle, pitch_angle, yaw_angle
    // result items
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // thrust_to_accel_x, _y, _z, torque_x_to_roll_rate, torque_y_to_roll_rate,
    // torque_x_to_pitch_rate, torque_y_to_pitch_rate, torque_x_to_yaw_rate,
    // torque_y_to_yaw_rate, torque_z_to_yaw_rate
    output logic [319:0] m_axis_tdata,
    output logic         m_axis_tuser    // secant_saturated
);

    localparam int SHIFT = 30 - ANGLE_FRAC_BITS;
    localparam int AW    = 16 + SHIFT;               // scaled angle width
    localparam int MW    = (AW > 34) ? AW : 34;      // reduction magnitude width
    localparam int RED   = (AW > 33) ? AW - 33 : 1;  // 2*pi subtract steps
    localparam int NIT   = (CORDIC_ITERATIONS > 32) ? 32 : CORDIC_ITERATIONS;
    localparam int DSTEP = 32;                       // quotient bits
    localparam logic [3:0] LANE_NEG = 4'b0110;       // entries with a minus sign
    localparam logic [MW-1:0] TWO_PI_MW = MW'(Q30_TWO_PI);

    // global advance: whole pipe moves unless the output holds an untaken item
    logic en;
    logic out_valid_reg;
    assign en            = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = en;
    assign cfg_ready     = 1'b1;

    // ---------------- configuration ----------------
    logic [31:0] inv_mass_reg, inv_inertia_xy_reg, inv_inertia_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inv_mass_reg       <= 32'd65536;
            inv_inertia_xy_reg <= 32'd65536;
            inv_inertia_z_reg  <= 32'd65536;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                CFG_INV_MASS:       inv_mass_reg       <= cfg_data;
                CFG_INV_INERTIA_XY: inv_inertia_xy_reg <= cfg_data;
                CFG_INV_INERTIA_Z:  inv_inertia_z_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // ---------------- angle reduction modulo 2*pi ----------------
    // works on |angle|; the sign rides along
    logic [MW-1:0] rm_reg [0:RED][3];
    logic          rs_reg [0:RED][3];
    logic          rv_reg [0:RED];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rv_reg[0] <= 1'b0;
        else if (en)
            rv_reg[0] <= s_axis_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic signed [AW-1:0] a;
                logic [AW-1:0]        am;
                a  = $signed({s_axis_tdata[16*l +: 16], {SHIFT{1'b0}}});
                am = a[AW-1] ? AW'(-a) : AW'(a);
                rm_reg[0][l] <= MW'(am);
                rs_reg[0][l] <= a[AW-1];
            end
        end
    end

    for (genvar j = 0; j < RED; j++)
    begin : g_red
        logic [MW-1:0] sub;
        assign sub = TWO_PI_MW << (RED - 1 - j);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                rv_reg[j+1] <= 1'b0;
            else if (en)
                rv_reg[j+1] <= rv_reg[j];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    rm_reg[j+1][l] <= (rm_reg[j][l] >= sub) ? rm_reg[j][l] - sub
                                                             : rm_reg[j][l];
                    rs_reg[j+1][l] <= rs_reg[j][l];
                end
            end
        end
    end

    // ---------------- fold + CORDIC rotation ----------------
    logic signed [33:0] cx_reg [0:NIT][3];
    logic signed [33:0] cy_reg [0:NIT][3];
    logic signed [33:0] cz_reg [0:NIT][3];
    logic               cn_reg [0:NIT][3];
    logic               cv_reg [0:NIT];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cv_reg[0] <= 1'b0;
        else if (en)
            cv_reg[0] <= rv_reg[RED];
    end

    // into [-pi, pi], then into [-pi/2, pi/2] with result negation
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic [33:0] m0, m1, m2;
                logic        s1, s2, fold;
                m0   = rm_reg[RED][l][33:0];
                s1   = (m0 > Q30_PI) ? !rs_reg[RED][l] : rs_reg[RED][l];
                m1   = (m0 > Q30_PI) ? Q30_TWO_PI - m0 : m0;
                fold = (m1 > Q30_HALF_PI);
                m2   = fold ? Q30_PI - m1 : m1;
                s2   = fold ? !s1 : s1;
                cx_reg[0][l] <= CORDIC_K;
                cy_reg[0][l] <= 34'sd0;
                cz_reg[0][l] <= s2 ? -$signed(m2) : $signed(m2);
                cn_reg[0][l] <= fold;
            end
        end
    end

    for (genvar i = 0; i < NIT; i++)
    begin : g_cordic
        logic [33:0] at;
        assign at = atan_q30(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                cv_reg[i+1] <= 1'b0;
            else if (en)
                cv_reg[i+1] <= cv_reg[i];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 3; l++)
                begin
                    logic signed [33:0] dx, dy;
                    dx = cy_reg[i][l] >>> i;
                    dy = cx_reg[i][l] >>> i;
                    if (!cz_reg[i][l][33])
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] - dx;
                        cy_reg[i+1][l] <= cy_reg[i][l] + dy;
                        cz_reg[i+1][l] <= cz_reg[i][l] - $signed(at);
                    end
                    else
                    begin
                        cx_reg[i+1][l] <= cx_reg[i][l] + dx;
                        cy_reg[i+1][l] <= cy_reg[i][l] - dy;
                        cz_reg[i+1][l] <= cz_reg[i][l] + $signed(at);
                    end
                    cn_reg[i+1][l] <= cn_reg[i][l];
                end
            end
        end
    end

    // ---------------- clamp to +-1 and apply fold sign ----------------
    logic signed [31:0] sin_reg [3];
    logic signed [31:0] cos_reg [3];
    logic               tv_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= 1'b0;
        else if (en)
            tv_reg <= cv_reg[NIT];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < 3; l++)
            begin
                logic signed [33:0] x, y;
                x = cx_reg[NIT][l];
                y = cy_reg[NIT][l];
                if (x > Q30_ONE)  x = Q30_ONE;
                if (x < -Q30_ONE) x = -Q30_ONE;
                if (y > Q30_ONE)  y = Q30_ONE;
                if (y < -Q30_ONE) y = -Q30_ONE;
                if (cn_reg[NIT][l])
                begin
                    x = -x;
                    y = -y;
                end
                sin_reg[l] <= 32'(y);
                cos_reg[l] <= 32'(x);
            end
        end
    end

    // ---------------- products, stage 1 ----------------
    logic signed [63:0] p1_msp_reg, p1_mcp_reg, p1_nc_reg, p1_ns_reg;
    logic signed [31:0] p1_sr_reg, p1_cr_reg, p1_sp_reg, p1_cd_reg;
    logic               p1_flag_reg, p1_v_reg;
    logic signed [32:0] m_s, j_s;
    logic               flag_next;
    logic signed [31:0] cd_next;

    assign m_s = $signed({1'b0, inv_mass_reg});
    assign j_s = $signed({1'b0, inv_inertia_xy_reg});
    // pitch cosine below one output lsb: secant clamps
    assign flag_next = (cos_reg[1] < SEC_FLOOR) && (cos_reg[1] > -SEC_FLOOR);
    assign cd_next   = flag_next ? (cos_reg[1][31] ? -SEC_FLOOR : SEC_FLOOR) : cos_reg[1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p1_v_reg <= 1'b0;
        else if (en)
            p1_v_reg <= tv_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_msp_reg  <= 64'(m_s * sin_reg[1]);
            p1_mcp_reg  <= 64'(m_s * cos_reg[1]);
            p1_nc_reg   <= 64'(j_s * cos_reg[2]);
            p1_ns_reg   <= 64'(j_s * sin_reg[2]);
            p1_sr_reg   <= sin_reg[0];
            p1_cr_reg   <= cos_reg[0];
            p1_sp_reg   <= sin_reg[1];
            p1_cd_reg   <= cd_next;
            p1_flag_reg <= flag_next;
        end
    end

    // ---------------- rounding, stage 2 ----------------
    logic signed [34:0] p2_mcp_reg, p2_ncq_reg, p2_nsq_reg;
    logic signed [63:0] p2_nc_reg, p2_ns_reg;
    logic signed [31:0] p2_sr_reg, p2_cr_reg, p2_sp_reg, p2_cd_reg;
    logic signed [31:0] p2_out0_reg;
    logic               p2_flag_reg, p2_v_reg;
    logic signed [67:0] ncq_next, nsq_next;

    assign ncq_next = rnd30(68'(p1_nc_reg));
    assign nsq_next = rnd30(68'(p1_ns_reg));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p2_v_reg <= 1'b0;
        else if (en)
            p2_v_reg <= p1_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_mcp_reg  <= 35'(rnd30(68'(p1_mcp_reg)));
            p2_ncq_reg  <= 35'(ncq_next);
            p2_nsq_reg  <= 35'(nsq_next);
            p2_out0_reg <= sat32(rnd30(68'(p1_msp_reg)));
            p2_nc_reg   <= p1_nc_reg;
            p2_ns_reg   <= p1_ns_reg;
            p2_sr_reg   <= p1_sr_reg;
            p2_cr_reg   <= p1_cr_reg;
            p2_sp_reg   <= p1_sp_reg;
            p2_cd_reg   <= p1_cd_reg;
            p2_flag_reg <= p1_flag_reg;
        end
    end

    // ---------------- products, stage 3 ----------------
    logic signed [66:0] p3_psr_reg, p3_pcr_reg, p3_pc_reg, p3_ps_reg;
    logic signed [63:0] p3_nc_reg, p3_ns_reg;
    logic signed [31:0] p3_cd_reg, p3_out0_reg, p3_out5_reg, p3_out6_reg;
    logic               p3_flag_reg, p3_v_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            p3_v_reg <= 1'b0;
        else if (en)
            p3_v_reg <= p2_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_psr_reg  <= 67'(p2_mcp_reg * p2_sr_reg);
            p3_pcr_reg  <= 67'(p2_mcp_reg * p2_cr_reg);
            p3_pc_reg   <= 67'(p2_ncq_reg * p2_sp_reg);
            p3_ps_reg   <= 67'(p2_nsq_reg * p2_sp_reg);
            p3_nc_reg   <= p2_nc_reg;
            p3_ns_reg   <= p2_ns_reg;
            p3_cd_reg   <= p2_cd_reg;
            p3_out0_reg <= p2_out0_reg;
            p3_out5_reg <= sat32(68'(p2_nsq_reg));
            p3_out6_reg <= sat32(68'(p2_ncq_reg));
            p3_flag_reg <= p2_flag_reg;
        end
    end

    // ---------------- secant dividers ----------------
    // four lanes share |cd|; dividend is |n| + |cd|/2 (round half away)
    div_lane_t   dl_reg [0:DSTEP][4];
    logic [30:0] dad_reg [0:DSTEP];
    carry_t      dc_reg [0:DSTEP];
    logic        dv_reg [0:DSTEP];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            dv_reg[0] <= 1'b0;
        else if (en)
            dv_reg[0] <= p3_v_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            logic [30:0] ad;
            ad = p3_cd_reg[31] ? 31'(-p3_cd_reg) : 31'(p3_cd_reg);
            dad_reg[0] <= ad;
            for (int l = 0; l < 4; l++)
            begin
                logic signed [66:0] n;
                logic [63:0]        an, an2;
                case (l)
                    0:       n = 67'(p3_nc_reg);
                    1:       n = 67'(p3_ns_reg);
                    2:       n = p3_pc_reg;
                    default: n = p3_ps_reg;
                endcase
                an  = n[66] ? 64'(-n) : 64'(n);
                an2 = an + 64'(ad[30:1]);
                dl_reg[0][l].rem <= an2[63:32];
                dl_reg[0][l].low <= an2[31:0];
                dl_reg[0][l].quo <= 32'd0;
                dl_reg[0][l].neg <= n[66] ^ p3_cd_reg[31] ^ LANE_NEG[l];
                dl_reg[0][l].ovf <= (an2[63:32] >= 32'(ad));
            end
            dc_reg[0].out0 <= p3_out0_reg;
            dc_reg[0].out1 <= sat32(-rnd30(68'(p3_psr_reg)));
            dc_reg[0].out2 <= sat32(rnd30(68'(p3_pcr_reg)));
            dc_reg[0].out5 <= p3_out5_reg;
            dc_reg[0].out6 <= p3_out6_reg;
            dc_reg[0].flag <= p3_flag_reg;
        end
    end

    for (genvar k = 0; k < DSTEP; k++)
    begin : g_div
        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
                dv_reg[k+1] <= 1'b0;
            else if (en)
                dv_reg[k+1] <= dv_reg[k];
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < 4; l++)
                begin
                    logic [31:0] t;
                    logic        qb;
                    t  = {dl_reg[k][l].rem[30:0], dl_reg[k][l].low[31]};
                    qb = (t >= 32'(dad_reg[k]));
                    dl_reg[k+1][l].rem <= qb ? t - 32'(dad_reg[k]) : t;
                    dl_reg[k+1][l].low <= {dl_reg[k][l].low[30:0], 1'b0};
                    dl_reg[k+1][l].quo <= {dl_reg[k][l].quo[30:0], qb};
                    dl_reg[k+1][l].neg <= dl_reg[k][l].neg;
                    dl_reg[k+1][l].ovf <= dl_reg[k][l].ovf;
                end
                dad_reg[k+1] <= dad_reg[k];
                dc_reg[k+1]  <= dc_reg[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic signed [31:0] q_res [4];
    logic [319:0]       out_data_reg;
    logic               out_user_reg;
    logic [31:0]        out9;

    always_comb
    begin
        for (int l = 0; l < 4; l++)
        begin
            logic signed [33:0] qs;
            qs = $signed({2'b00, dl_reg[DSTEP][l].quo});
            if (dl_reg[DSTEP][l].neg)
                qs = -qs;
            if (dl_reg[DSTEP][l].ovf)
                q_res[l] = dl_reg[DSTEP][l].neg ? SAT_MIN[31:0] : SAT_MAX[31:0];
            else
                q_res[l] = sat32(68'(qs));
        end
    end

    assign out9 = inv_inertia_z_reg[31] ? SAT_MAX[31:0] : inv_inertia_z_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (en)
            out_valid_reg <= dv_reg[DSTEP];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_data_reg <= {out9, q_res[3], q_res[2], dc_reg[DSTEP].out6,
                             dc_reg[DSTEP].out5, q_res[1], q_res[0],
                             dc_reg[DSTEP].out2, dc_reg[DSTEP].out1,
                             dc_reg[DSTEP].out0};
            out_user_reg <= dc_reg[DSTEP].flag;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

endmodule

[bench/qigm_checker.sv]
// ----------------------------------------------------------------------------
// qigm_checker
// Watches the config, input and result channels of the gain matrix block,
// predicts every result item and compares it field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module qigm_checker
    import qigm_pkg::*;
#(
    parameter int CORDIC_ITERATIONS = 16,
    parameter int ANGLE_FRAC_BITS   = 13
)
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         cfg_valid,
    input  logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [31:0]  cfg_data,
    input  logic         s_axis_tvalid,
    input  logic         s_axis_tready,
    input  logic [47:0]  s_axis_tdata,
    input  logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    input  logic [319:0] m_axis_tdata,
    input  logic         m_axis_tuser,
    output int           fail_count,
    output int           gains_pending
);

    localparam longint ONE_Q30     = 64'sd1073741824;
    localparam longint PI_Q30      = 64'sd3373259426;
    localparam longint HALF_PI_Q30 = 64'sd1686629713;
    localparam longint TWO_PI_Q30  = 64'sd6746518852;
    localparam longint GAIN_K      = 64'sd652032874;
    localparam longint COS_FLOOR   = 64'sd16384;

    localparam longint ARCTAN_Q30 [0:31] = '{
        843314857, 497837829, 263043837, 133525159, 67021687, 33543516,
        16775851, 8388437, 4194283, 2097149, 1048576, 524288, 262144, 131072,
        65536, 32768, 16384, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32,
        16, 8, 4, 2, 1, 1
    };

    localparam string ENTRY_NAME [0:9] = '{
        "thrust_to_accel_x", "thrust_to_accel_y", "thrust_to_accel_z",
        "torque_x_to_roll_rate", "torque_y_to_roll_rate",
        "torque_x_to_pitch_rate", "torque_y_to_pitch_rate",
        "torque_x_to_yaw_rate", "torque_y_to_yaw_rate", "torque_z_to_yaw_rate"
    };

    typedef struct packed {
        logic [9:0][31:0] entry;
        logic             sec_sat;
    } gain_set_t;

    logic [31:0] mass_recip;
    logic [31:0] inertia_xy_recip;
    logic [31:0] inertia_z_recip;
    gain_set_t   expected_gains [$];

    function automatic longint round_q30(input longint v);
        return (v + (64'sd1 <<< 29)) >>> 30;
    endfunction

    // quotient rounded half away from zero
    function automatic longint div_away(input longint n, input longint d);
        longint unsigned an;
        longint unsigned ad;
        longint          q;
        an = (n < 0) ? -n : n;
        ad = (d < 0) ? -d : d;
        q  = longint'((an + ad / 2) / ad);
        return ((n < 0) != (d < 0)) ? -q : q;
    endfunction

    function automatic logic [31:0] clip32(input longint v);
        if (v > 64'sd2147483647)
            return 32'h7FFF_FFFF;
        if (v < -64'sd2147483648)
            return 32'h8000_0000;
        return v[31:0];
    endfunction

    function automatic void angle_sin_cos(input logic [15:0] ang,
                                          output longint s, output longint c);
        longint r;
        longint x;
        longint y;
        longint dx;
        longint dy;
        bit     flip;
        r    = longint'($signed(ang)) * (64'sd1 <<< (30 - ANGLE_FRAC_BITS));
        r    = r % TWO_PI_Q30;
        flip = 0;
        if (r > PI_Q30)
            r -= TWO_PI_Q30;
        else if (r < -PI_Q30)
            r += TWO_PI_Q30;
        // fold into the right half plane, negate afterwards
        if (r > HALF_PI_Q30)
        begin
            r -= PI_Q30;
            flip = 1;
        end
        else if (r < -HALF_PI_Q30)
        begin
            r += PI_Q30;
            flip = 1;
        end
        x = GAIN_K;
        y = 0;
        for (int i = 0; i < CORDIC_ITERATIONS && i < 32; i++)
        begin
            dx = y >>> i;
            dy = x >>> i;
            if (r >= 0)
            begin
                x -= dx;
                y += dy;
                r -= ARCTAN_Q30[i];
            end
            else
            begin
                x += dx;
                y -= dy;
                r += ARCTAN_Q30[i];
            end
        end
        if (x > ONE_Q30) x = ONE_Q30;
        if (x < -ONE_Q30) x = -ONE_Q30;
        if (y > ONE_Q30) y = ONE_Q30;
        if (y < -ONE_Q30) y = -ONE_Q30;
        s = flip ? -y : y;
        c = flip ? -x : x;
    endfunction

    function automatic gain_set_t predict_gains(input logic [47:0] angles);
        gain_set_t g;
        longint    sr, cr, sp, cp, sy, cy;
        longint    m, j, mcp, cdiv, jc, js, jcq, jsq;
        angle_sin_cos(angles[15:0], sr, cr);
        angle_sin_cos(angles[31:16], sp, cp);
        angle_sin_cos(angles[47:32], sy, cy);
        m         = longint'(mass_recip);
        j         = longint'(inertia_xy_recip);
        mcp       = round_q30(m * cp);
        g.sec_sat = (cp < COS_FLOOR) && (cp > -COS_FLOOR);
        cdiv      = g.sec_sat ? ((cp < 0) ? -COS_FLOOR : COS_FLOOR) : cp;
        jc        = j * cy;
        js        = j * sy;
        jcq       = round_q30(jc);
        jsq       = round_q30(js);
        g.entry[0] = clip32(round_q30(m * sp));
        g.entry[1] = clip32(-round_q30(mcp * sr));
        g.entry[2] = clip32(round_q30(mcp * cr));
        g.entry[3] = clip32(div_away(jc, cdiv));
        g.entry[4] = clip32(-div_away(js, cdiv));
        g.entry[5] = clip32(jsq);
        g.entry[6] = clip32(jcq);
        g.entry[7] = clip32(-div_away(jcq * sp, cdiv));
        g.entry[8] = clip32(div_away(jsq * sp, cdiv));
        g.entry[9] = clip32(longint'(inertia_z_recip));
        return g;
    endfunction

    assign gains_pending = expected_gains.size();

    always @(posedge clk or negedge rst_n)
    begin
        gain_set_t want;
        int        errs;
        if (!rst_n)
        begin
            mass_recip       <= 32'd65536;
            inertia_xy_recip <= 32'd65536;
            inertia_z_recip  <= 32'd65536;
            fail_count       <= 0;
            expected_gains.delete();
        end
        else
        begin
            errs = 0;
            // registers only change while idle, so order against items is moot
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_INV_MASS:       mass_recip       <= cfg_data;
                    CFG_INV_INERTIA_XY: inertia_xy_recip <= cfg_data;
                    CFG_INV_INERTIA_Z:  inertia_z_recip  <= cfg_data;
                    default: ;
                endcase
            end
            if (s_axis_tvalid && s_axis_tready)
                expected_gains.push_back(predict_gains(s_axis_tdata));
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_gains.size() == 0)
                begin
                    $error("result item with no item pending");
                    errs++;
                end
                else
                begin
                    want = expected_gains.pop_front();
                    for (int i = 0; i < 10; i++)
                    begin
                        if (m_axis_tdata[32*i +: 32] !== want.entry[i])
                        begin
                            $error("%s: expected %0d, got %0d", ENTRY_NAME[i],
                                   $signed(want.entry[i]),
                                   $signed(m_axis_tdata[32*i +: 32]));
                            errs++;
                        end
                    end
                    if (m_axis_tuser !== want.sec_sat)
                    begin
                        $error("secant_saturated: expected %0d, got %0d",
                               want.sec_sat, m_axis_tuser);
                        errs++;
                    end
                end
            end
            fail_count <= fail_count + errs;
        end
    end

endmodule

[bench/quadrotor_input_gain_matrix_test.sv]
// ----------------------------------------------------------------------------
// quadrotor_input_gain_matrix_test
// Drives angle items and gain register writes into the block under several
// register settings, with random gaps and stalls on both streams; the checker
// predicts and compares every result item.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module quadrotor_input_gain_matrix_test;
    import qigm_pkg::*;

    // index 3 is not a register; writes to it must be dropped
    localparam logic [1:0] CFG_NONE    = 2'd3;
    localparam int         DRAIN_WAIT  = 80;     // longer than the pipeline latency
    localparam int         RANDOM_ITEMS = 1100;
    // pitch of pi/2 in Q2.13, where the cosine vanishes
    localparam int         QUARTER_TURN = 12868;

    logic         clk;
    logic         rst_n;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [1:0]   cfg_index;
    logic [31:0]  cfg_data;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [47:0]  s_axis_tdata;   // roll_angle, pitch_angle, yaw_angle
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [319:0] m_axis_tdata;   // ten Q16.16 entries, thrust_to_accel_x lowest
    logic         m_axis_tuser;   // secant_saturated
    int           fail_count;
    int           gains_pending;
    bit           steady;         // no gaps or stalls while set
    int           stall_left;

    quadrotor_input_gain_matrix dut (.*);

    qigm_checker checker_i (.*);

    initial clk = 1'b0;
    always #1 clk = ~clk;

    // hard stop if anything hangs
    initial
    begin
        #2000000;
        $display("TEST FAILED");
        $finish;
    end

    // mostly short gaps, a few long ones
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 50)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // result side back-pressure
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= 0;
        end
        else if (stall_left > 0)
        begin
            m_axis_tready <= 1'b0;
            stall_left    <= stall_left - 1;
        end
        else
        begin
            int len;
            len = pick_gap();
            m_axis_tready <= (len == 0);
            stall_left    <= (len > 0) ? len - 1 : 0;
        end
    end

    task automatic send_angles(input logic [15:0] roll, input logic [15:0] pitch,
                               input logic [15:0] yaw);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {yaw, pitch, roll};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    // stop sending and wait for every pending result, then let the pipe empty
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (gains_pending != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_gains(input logic [31:0] m, input logic [31:0] jxy,
                             input logic [31:0] jz);
        write_reg(CFG_INV_MASS, m);
        write_reg(CFG_INV_INERTIA_XY, jxy);
        write_reg(CFG_INV_INERTIA_Z, jz);
    endtask

    task automatic random_angles(input int count);
        logic [15:0] a [3];
        int          kind;
        for (int n = 0; n < count; n++)
        begin
            kind = $urandom_range(0, 9);
            for (int k = 0; k < 3; k++)
            begin
                if (kind < 4)
                    a[k] = 16'($urandom());   // whole 16-bit range, wraps mod 2 pi
                else
                    a[k] = 16'(int'($urandom_range(0, 2 * 25736)) - 25736);
            end
            // pitch close to +-pi/2 to hit the secant clamp
            if (kind >= 8)
                a[1] = 16'((($urandom_range(0, 1) != 0) ? QUARTER_TURN : -QUARTER_TURN)
                           + int'($urandom_range(0, 40)) - 20);
            send_angles(a[0], a[1], a[2]);
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_INV_MASS;
        cfg_data      = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        steady        = 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: reset gains, field extremes, pitch at the singularity
        send_angles(16'sd0, 16'sd0, 16'sd0);
        send_angles(16'sd25736, -16'sd25736, 16'sd25736);
        send_angles(-16'sd25736, 16'sd25736, -16'sd25736);
        send_angles(16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
        send_angles(16'sh8000, 16'sh8000, 16'sh8000);
        send_angles(16'sd6434, 16'(QUARTER_TURN), 16'sd6434);
        send_angles(-16'sd6434, 16'(-QUARTER_TURN), 16'sd12868);
        send_angles(16'sd100, 16'(QUARTER_TURN - 1), -16'sd100);
        send_angles(16'sd100, 16'(QUARTER_TURN + 1), -16'sd100);
        send_angles(16'sd1, 16'(-QUARTER_TURN - 3 * QUARTER_TURN / 2), 16'sd1);
        drain();

        // largest gains: every entry saturates somewhere; ignored index too
        set_gains(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(CFG_NONE, 32'h1234_5678);
        send_angles(16'sd0, 16'sd0, 16'sd0);
        send_angles(16'sd12000, 16'(QUARTER_TURN), -16'sd12000);
        send_angles(-16'sd3000, 16'(-QUARTER_TURN), 16'sd20000);
        random_angles(RANDOM_ITEMS / 5);
        drain();

        // zero gains
        set_gains(32'd0, 32'd0, 32'd0);
        send_angles(16'sd5000, 16'(QUARTER_TURN), 16'sd5000);
        random_angles(RANDOM_ITEMS / 10);
        drain();

        // fully random gains, with a stretch of no gaps or stalls
        set_gains($urandom(), $urandom(), $urandom());
        steady = 1'b1;
        random_angles(RANDOM_ITEMS / 5);
        steady = 1'b0;
        random_angles(RANDOM_ITEMS / 10);
        drain();

        // realistic small gains
        set_gains($urandom_range(0, 32'h0004_0000), $urandom_range(0, 32'h0020_0000),
                  $urandom_range(0, 32'h0020_0000));
        random_angles(RANDOM_ITEMS / 5);
        drain();

        set_gains($urandom(), $urandom(), $urandom());
        random_angles(RANDOM_ITEMS / 5);
        drain();

        if (fail_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
